// ===== src/wav_header_parser_assert.svh =====
// assertion macros shared by the wave header parser modules
// expects clk and rst_n in scope at the point of use
`ifndef WAV_HEADER_PARSER_ASSERT_SVH
`define WAV_HEADER_PARSER_ASSERT_SVH

// same-cycle implication
`define WAVP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wavp assertion failed");

// next-cycle implication
`define WAVP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wavp assertion failed");

`endif

// ===== src/wavp_pkg.sv =====
// shared types and constants for the wave header parser
// used by the controller, datapath and top level
package wavp_pkg;

  localparam logic [31:0] TAG_RIFF      = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE      = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT       = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA      = 32'h6174_6164;
  localparam logic [31:0] FMT_EXT_SIZE  = 32'd18;
  localparam logic [16:0] BASE_OFFSET   = 17'd44;
  localparam logic [16:0] EXT_OFFSET    = 17'd46;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_RIFF = 3'd1,
    ST_BAD_WAVE = 3'd2,
    ST_BAD_FMT  = 3'd3,
    ST_BAD_DATA = 3'd4,
    ST_ZERO     = 3'd5,
    ST_TRUNC    = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    LD_NONE,
    LD_FMT,
    LD_CH,
    LD_RATE,
    LD_BRATE,
    LD_ALIGN,
    LD_BITS,
    LD_EXTRA,
    LD_SIZE
  } ld_sel_t;

  typedef struct packed {
    logic    shift_en;
    ld_sel_t ld_sel;
    logic    skip_dec;
    logic    div_start;
    logic    out_ld;
    status_t out_status;
  } dp_cmd_t;

  typedef struct packed {
    logic tag_riff;
    logic tag_wave;
    logic tag_fmt;
    logic tag_data;
    logic fmt18;
    logic v16_zero;
    logic skip_last;
    logic zero_field;
    logic out_free;
    logic div_done;
  } dp_stat_t;

endpackage

// ===== src/wavp_in_if.sv =====
// byte input channel of the wave header parser
// no dependencies
interface wavp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, data_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

// ===== src/wavp_out_if.sv =====
// result channel of the wave header parser
// no dependencies
interface wavp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] channel_count;
  logic [31:0] sample_rate;
  logic [31:0] bit_rate;
  logic [15:0] block_align;
  logic [15:0] bits_per_sample;
  logic [16:0] data_offset;
  logic [31:0] data_size;
  logic [31:0] frame_count;

  modport source (
    output valid, status, channel_count, sample_rate, bit_rate, block_align,
           bits_per_sample, data_offset, data_size, frame_count,
    input  ready
  );
  modport sink (
    input  valid, status, channel_count, sample_rate, bit_rate, block_align,
           bits_per_sample, data_offset, data_size, frame_count,
    output ready
  );
endinterface

// ===== src/wav_header_parser.sv =====
// wave header parser top level: byte input channel in_ch, result channel out_ch.
// A file streams in one byte per transaction; first_byte restarts the parse at
// that byte and last_byte marks the end of the file. One result leaves per file:
// when the data size field completes, at the first bad tag or zero field, or
// with status truncated when last_byte comes before the header is done. Later
// bytes are taken and dropped until the next first_byte.
// Throughput is one byte per cycle while parsing, except under the result stall below.
// An error or truncation result is registered at the byte that causes it and is
// visible the next cycle. A good header runs the frame count through a 32-step
// radix-2 divider; the result is loaded when the divider finishes, and in_ch.ready
// stays low until then.
// out_ch is a single result register: while it holds an untaken result the
// parser keeps accepting bytes that cannot produce a result (idle bytes without
// first_byte) and stalls any other byte until the result is taken.
// Synchronous reset leaves the parser idle, waiting for a first byte, with no
// result pending.
// depends on wavp_pkg, wavp_in_if, wavp_out_if, wavp_ctrl and wavp_dp
module wav_header_parser
  import wavp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  wavp_in_if.sink     in_ch,
  wavp_out_if.source  out_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  wavp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_first (in_ch.first_byte),
    .in_last  (in_ch.last_byte),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wavp_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_byte (in_ch.data_byte),
    .cmd     (cmd),
    .stat    (stat),
    .out_ch  (out_ch)
  );

endmodule

// ===== src/wavp_div.sv =====
// radix-2 restoring divider, 32-bit dividend by 16-bit divisor
// one quotient bit per cycle; uses the shared assertion macros
`include "wav_header_parser_assert.svh"

module wavp_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [15:0] rem_r;
  logic [31:0] quot_r;
  logic [16:0] trial;
  logic [16:0] diff;
  logic        q_bit;

  // remainder stays below the divisor, so 16 bits plus the shifted-in bit suffice
  assign trial = {rem_r, quot_r[31]};
  assign diff  = trial - {1'b0, divisor};
  assign q_bit = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd31;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quot_r <= dividend;
    end else if (busy_r) begin
      rem_r  <= q_bit ? diff[15:0] : trial[15:0];
      quot_r <= {quot_r[30:0], q_bit};
    end
  end

  assign done     = done_r;
  assign quotient = quot_r;

  `WAVP_ASSERT_IMPL(a_no_restart_busy, start, !busy_r)
  `WAVP_ASSERT_NEXT(a_done_ends_run, busy_r && (cnt_r == 5'd0) && !start, done_r && !busy_r)

endmodule

// ===== src/wavp_dp.sv =====
// datapath: field assembly, held header fields, skip counter, divider
// and the result register; depends on wavp_pkg, wavp_div and wavp_out_if
module wavp_dp
  import wavp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_byte,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  wavp_out_if.source        out_ch
);

  logic [31:0] field_shift_r;
  logic        fmt18_r;
  logic [15:0] channels_r;
  logic [31:0] rate_r;
  logic [31:0] byte_rate_r;
  logic [15:0] align_r;
  logic [15:0] bits_r;
  logic [15:0] extra_r;
  logic [15:0] skip_r;
  logic [31:0] size_r;

  logic        out_valid_r;
  status_t     out_status_r;
  logic [15:0] out_ch_r;
  logic [31:0] out_rate_r;
  logic [31:0] out_brate_r;
  logic [15:0] out_align_r;
  logic [15:0] out_bits_r;
  logic [16:0] out_offset_r;
  logic [31:0] out_size_r;
  logic [31:0] out_frames_r;

  logic [31:0] asm_val;
  logic [15:0] v16;
  logic        div_done;
  logic [31:0] quotient;
  logic        ok;

  // incoming byte goes in at the top, little-endian
  assign asm_val = {in_byte, field_shift_r[31:8]};
  assign v16     = asm_val[31:16];

  wavp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (asm_val),
    .divisor  (align_r),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.shift_en) begin
      field_shift_r <= asm_val;
    end
    if (cmd.skip_dec) begin
      skip_r <= skip_r - 16'd1;
    end
    case (cmd.ld_sel)
      LD_FMT:   fmt18_r     <= (asm_val == FMT_EXT_SIZE);
      LD_CH:    channels_r  <= v16;
      LD_RATE:  rate_r      <= asm_val;
      LD_BRATE: byte_rate_r <= asm_val;
      LD_ALIGN: align_r     <= v16;
      LD_BITS:  bits_r      <= v16;
      LD_EXTRA: begin
        extra_r <= v16;
        skip_r  <= v16;
      end
      LD_SIZE:  size_r      <= asm_val;
      default: ;
    endcase
  end

  assign ok = (cmd.out_status == ST_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_status_r <= cmd.out_status;
      out_ch_r     <= ok ? channels_r : 16'd0;
      out_rate_r   <= ok ? rate_r : 32'd0;
      out_brate_r  <= ok ? {byte_rate_r[28:0], 3'b000} : 32'd0;
      out_align_r  <= ok ? align_r : 16'd0;
      out_bits_r   <= ok ? bits_r : 16'd0;
      if (!ok) begin
        out_offset_r <= '0;
      end else if (fmt18_r) begin
        out_offset_r <= EXT_OFFSET + {1'b0, extra_r};
      end else begin
        out_offset_r <= BASE_OFFSET;
      end
      out_size_r   <= ok ? size_r : 32'd0;
      out_frames_r <= ok ? quotient : 32'd0;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.channel_count   = out_ch_r;
  assign out_ch.sample_rate     = out_rate_r;
  assign out_ch.bit_rate        = out_brate_r;
  assign out_ch.block_align     = out_align_r;
  assign out_ch.bits_per_sample = out_bits_r;
  assign out_ch.data_offset     = out_offset_r;
  assign out_ch.data_size       = out_size_r;
  assign out_ch.frame_count     = out_frames_r;

  assign stat.tag_riff   = (asm_val == TAG_RIFF);
  assign stat.tag_wave   = (asm_val == TAG_WAVE);
  assign stat.tag_fmt    = (asm_val == TAG_FMT);
  assign stat.tag_data   = (asm_val == TAG_DATA);
  assign stat.fmt18      = fmt18_r;
  assign stat.v16_zero   = (v16 == 16'd0);
  assign stat.skip_last  = (skip_r == 16'd1);
  assign stat.zero_field = (channels_r == 16'd0) || (rate_r == 32'd0) || (align_r == 16'd0);
  assign stat.out_free   = !out_valid_r || out_ch.ready;
  assign stat.div_done   = div_done;

endmodule

// ===== src/wavp_ctrl.sv =====
// parse controller: header phase sequencing, byte counting and result issue
// depends on wavp_pkg and the shared assertion macros
`include "wav_header_parser_assert.svh"

module wavp_ctrl
  import wavp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_first,
  input  logic     in_last,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_RIFF, PH_RSIZE, PH_WAVE, PH_FMT, PH_FSIZE, PH_FTAG, PH_CH,
    PH_RATE, PH_BRATE, PH_ALIGN, PH_BITS, PH_EXTRA, PH_SKIP, PH_DTAG, PH_DSIZE,
    PH_DIV
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  phase_t     eph;
  logic [1:0] ecnt;
  logic       acc;
  logic       short_field;
  logic       complete;
  logic       emit;
  status_t    estat;

  // an idle stray byte can be dropped even while a result waits
  assign in_ready = (phase_r != PH_DIV) &&
                    (stat.out_free || ((phase_r == PH_IDLE) && !in_first));
  assign acc = in_valid && in_ready;

  // a first byte restarts the parse at that very byte
  assign eph  = in_first ? PH_RIFF : phase_r;
  assign ecnt = in_first ? 2'd0 : cnt_r;

  always_comb begin
    case (eph)
      PH_FTAG, PH_CH, PH_ALIGN, PH_BITS, PH_EXTRA: short_field = 1'b1;
      default:                                     short_field = 1'b0;
    endcase
  end

  assign complete = short_field ? (ecnt == 2'd1) : (ecnt == 2'd3);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    emit      = 1'b0;
    estat     = ST_OK;

    if (acc && (eph != PH_IDLE)) begin
      phase_nxt = eph;
      cnt_nxt   = ecnt;
      if (eph == PH_SKIP) begin
        cmd.skip_dec = 1'b1;
        if (stat.skip_last) begin
          phase_nxt = PH_DTAG;
        end
      end else begin
        cmd.shift_en = 1'b1;
        if (!complete) begin
          cnt_nxt = ecnt + 2'd1;
        end else begin
          cnt_nxt = 2'd0;
          unique case (eph)
            PH_RIFF: begin
              if (!stat.tag_riff) begin
                emit  = 1'b1;
                estat = ST_BAD_RIFF;
              end
              phase_nxt = PH_RSIZE;
            end
            PH_RSIZE: phase_nxt = PH_WAVE;
            PH_WAVE: begin
              if (!stat.tag_wave) begin
                emit  = 1'b1;
                estat = ST_BAD_WAVE;
              end
              phase_nxt = PH_FMT;
            end
            PH_FMT: begin
              if (!stat.tag_fmt) begin
                emit  = 1'b1;
                estat = ST_BAD_FMT;
              end
              phase_nxt = PH_FSIZE;
            end
            PH_FSIZE: begin
              cmd.ld_sel = LD_FMT;
              phase_nxt  = PH_FTAG;
            end
            PH_FTAG: phase_nxt = PH_CH;
            PH_CH: begin
              cmd.ld_sel = LD_CH;
              phase_nxt  = PH_RATE;
            end
            PH_RATE: begin
              cmd.ld_sel = LD_RATE;
              phase_nxt  = PH_BRATE;
            end
            PH_BRATE: begin
              cmd.ld_sel = LD_BRATE;
              phase_nxt  = PH_ALIGN;
            end
            PH_ALIGN: begin
              cmd.ld_sel = LD_ALIGN;
              phase_nxt  = PH_BITS;
            end
            PH_BITS: begin
              cmd.ld_sel = LD_BITS;
              phase_nxt  = stat.fmt18 ? PH_EXTRA : PH_DTAG;
            end
            PH_EXTRA: begin
              cmd.ld_sel = LD_EXTRA;
              phase_nxt  = stat.v16_zero ? PH_DTAG : PH_SKIP;
            end
            PH_DTAG: begin
              if (!stat.tag_data) begin
                emit  = 1'b1;
                estat = ST_BAD_DATA;
              end
              phase_nxt = PH_DSIZE;
            end
            PH_DSIZE: begin
              cmd.ld_sel = LD_SIZE;
              if (stat.zero_field) begin
                emit  = 1'b1;
                estat = ST_ZERO;
              end else begin
                cmd.div_start = 1'b1;
                phase_nxt     = PH_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      // last byte of an unfinished header
      if (!emit && in_last && (phase_nxt != PH_DIV)) begin
        emit  = 1'b1;
        estat = ST_TRUNC;
      end
    end

    if ((phase_r == PH_DIV) && stat.div_done) begin
      emit  = 1'b1;
      estat = ST_OK;
    end

    if (emit) begin
      cmd.out_ld     = 1'b1;
      cmd.out_status = estat;
      phase_nxt      = PH_IDLE;
      cnt_nxt        = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= 2'd0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `WAVP_ASSERT_IMPL(a_done_in_div, stat.div_done, phase_r == PH_DIV)
  `WAVP_ASSERT_IMPL(a_load_into_free, cmd.out_ld, stat.out_free)
  `WAVP_ASSERT_NEXT(a_first_starts_riff, acc && in_first && !in_last, phase_r == PH_RIFF)

endmodule

// ===== tb/wav_header_parser_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for wav_header_parser: streams whole and damaged wave headers
// through in_ch and checks every result on out_ch against a local header parser model
// depends on wavp_pkg, wavp_in_if, wavp_out_if and wav_header_parser
module wav_header_parser_tb;
  import wavp_pkg::*;

  localparam int IDLE_PCT     = 35;
  localparam int CALM_FROM    = 2000;
  localparam int CALM_TO      = 5000;
  localparam int RANDOM_ITEMS = 1540;
  localparam int DRAIN_CYCLES = 50;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int NO_CUT       = -1;
  localparam int MAX_REPORTS  = 100;

  typedef enum logic [3:0] {
    WAIT_FIRST, GET_RIFF, GET_RSIZE, GET_WAVE, GET_FMT, GET_FSIZE, GET_FTAG, GET_CH,
    GET_RATE, GET_BRATE, GET_ALIGN, GET_BITS, GET_EXTRA, SKIP_EXTRA, GET_DTAG, GET_DSIZE
  } hdr_phase_t;

  typedef enum int { DMG_NONE, DMG_RIFF, DMG_WAVE, DMG_FMT, DMG_DATA } damage_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } stream_byte_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] bit_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [16:0] data_offset;
    logic [31:0] data_size;
    logic [31:0] frame_count;
  } wav_summary_t;

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_count = 0;
  int   mismatches = 0;
  int   file_items = 0;
  logic in_fire = 1'b0;
  logic calm;

  stream_byte_t byte_queue[$];
  stream_byte_t next_byte;
  wav_summary_t header_results[$];

  // parser model state
  hdr_phase_t  phase = WAIT_FIRST;
  int          field_pos = 0;
  logic [31:0] shreg = '0;
  logic [31:0] fmt_len_q = '0;
  logic [15:0] chans_q = '0;
  logic [31:0] rate_q = '0;
  logic [31:0] brate_q = '0;
  logic [15:0] align_q = '0;
  logic [15:0] bits_q = '0;
  logic [15:0] extra_q = '0;
  logic [15:0] skip_q = '0;
  logic [31:0] dsize_q = '0;
  logic        file_done = 1'b1;

  wavp_in_if  in_if ();
  wavp_out_if out_if ();

  wav_header_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #6 clk = ~clk;

  assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (mismatches < MAX_REPORTS)
      $display("mismatch at cycle %0d, %s: got %0h expected %0h", cycle_count, what, got,
               want);
    mismatches++;
  endtask

  task automatic close_file(input status_t st);
    wav_summary_t r;
    r = '0;
    r.status = st;
    if (st == ST_OK) begin
      r.channel_count   = chans_q;
      r.sample_rate     = rate_q;
      r.bit_rate        = brate_q << 3;
      r.block_align     = align_q;
      r.bits_per_sample = bits_q;
      r.data_offset     = (fmt_len_q == FMT_EXT_SIZE) ? EXT_OFFSET + 17'(extra_q) : BASE_OFFSET;
      r.data_size       = dsize_q;
      r.frame_count     = dsize_q / align_q;
    end
    header_results.push_back(r);
    file_done = 1'b1;
    phase = WAIT_FIRST;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic first, input logic last);
    int need;
    logic [15:0] v16;
    if (first) begin
      phase = GET_RIFF;
      field_pos = 0;
      shreg = '0;
      fmt_len_q = '0;
      chans_q = '0;
      rate_q = '0;
      brate_q = '0;
      align_q = '0;
      bits_q = '0;
      extra_q = '0;
      skip_q = '0;
      dsize_q = '0;
      file_done = 1'b0;
    end
    if (file_done || phase == WAIT_FIRST) return;
    if (phase == SKIP_EXTRA) begin
      skip_q--;
      if (skip_q == 0) phase = GET_DTAG;
      if (last) close_file(ST_TRUNC);
      return;
    end
    shreg = {b, shreg[31:8]};
    case (phase)
      GET_FTAG, GET_CH, GET_ALIGN, GET_BITS, GET_EXTRA: need = 2;
      default: need = 4;
    endcase
    if (field_pos + 1 < need) begin
      field_pos++;
      if (last) close_file(ST_TRUNC);
      return;
    end
    field_pos = 0;
    v16 = shreg[31:16];
    case (phase)
      GET_RIFF: begin
        if (shreg != TAG_RIFF) begin
          close_file(ST_BAD_RIFF);
          return;
        end
        phase = GET_RSIZE;
      end
      GET_RSIZE: phase = GET_WAVE;
      GET_WAVE: begin
        if (shreg != TAG_WAVE) begin
          close_file(ST_BAD_WAVE);
          return;
        end
        phase = GET_FMT;
      end
      GET_FMT: begin
        if (shreg != TAG_FMT) begin
          close_file(ST_BAD_FMT);
          return;
        end
        phase = GET_FSIZE;
      end
      GET_FSIZE: begin
        fmt_len_q = shreg;
        phase = GET_FTAG;
      end
      GET_FTAG: phase = GET_CH;
      GET_CH: begin
        chans_q = v16;
        phase = GET_RATE;
      end
      GET_RATE: begin
        rate_q = shreg;
        phase = GET_BRATE;
      end
      GET_BRATE: begin
        brate_q = shreg;
        phase = GET_ALIGN;
      end
      GET_ALIGN: begin
        align_q = v16;
        phase = GET_BITS;
      end
      GET_BITS: begin
        bits_q = v16;
        phase = (fmt_len_q == FMT_EXT_SIZE) ? GET_EXTRA : GET_DTAG;
      end
      GET_EXTRA: begin
        extra_q = v16;
        skip_q = v16;
        phase = (v16 != 0) ? SKIP_EXTRA : GET_DTAG;
      end
      GET_DTAG: begin
        if (shreg != TAG_DATA) begin
          close_file(ST_BAD_DATA);
          return;
        end
        phase = GET_DSIZE;
      end
      default: begin
        dsize_q = shreg;
        if (align_q == 0 || rate_q == 0 || chans_q == 0) close_file(ST_ZERO);
        else close_file(ST_OK);
        return;
      end
    endcase
    if (last) close_file(ST_TRUNC);
  endtask

  task automatic check_result();
    wav_summary_t want;
    if (header_results.size() == 0) begin
      report_mismatch("result with none expected", out_if.status, 0);
      return;
    end
    want = header_results.pop_front();
    if (out_if.status !== want.status)
      report_mismatch("status", out_if.status, want.status);
    if (out_if.channel_count !== want.channel_count)
      report_mismatch("channel_count", out_if.channel_count, want.channel_count);
    if (out_if.sample_rate !== want.sample_rate)
      report_mismatch("sample_rate", out_if.sample_rate, want.sample_rate);
    if (out_if.bit_rate !== want.bit_rate)
      report_mismatch("bit_rate", out_if.bit_rate, want.bit_rate);
    if (out_if.block_align !== want.block_align)
      report_mismatch("block_align", out_if.block_align, want.block_align);
    if (out_if.bits_per_sample !== want.bits_per_sample)
      report_mismatch("bits_per_sample", out_if.bits_per_sample, want.bits_per_sample);
    if (out_if.data_offset !== want.data_offset)
      report_mismatch("data_offset", out_if.data_offset, want.data_offset);
    if (out_if.data_size !== want.data_size)
      report_mismatch("data_size", out_if.data_size, want.data_size);
    if (out_if.frame_count !== want.frame_count)
      report_mismatch("frame_count", out_if.frame_count, want.frame_count);
  endtask

  task automatic push_byte(input logic [7:0] d, input logic f, input logic l);
    byte_queue.push_back('{data_byte: d, first_byte: f, last_byte: l});
  endtask

  task automatic put_le(ref logic [7:0] img[$], input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) img.push_back(v[8*i +: 8]);
  endtask

  // builds one file image, optionally damages a tag, then streams it whole or cut short
  task automatic make_file(input logic [31:0] fmt_len, input logic [15:0] extra,
                           input logic [15:0] ch, input logic [31:0] rate,
                           input logic [31:0] brate, input logic [15:0] align,
                           input logic [15:0] bits, input logic [31:0] dsize,
                           input damage_t dmg, input int cut, input bit with_last,
                           input int trail);
    logic [7:0] img[$];
    int dtag_at;
    int pos;
    int n;
    int tail;
    img = {};
    put_le(img, TAG_RIFF, 4);
    put_le(img, $urandom, 4);
    put_le(img, TAG_WAVE, 4);
    put_le(img, TAG_FMT, 4);
    put_le(img, fmt_len, 4);
    put_le(img, $urandom, 2);
    put_le(img, ch, 2);
    put_le(img, rate, 4);
    put_le(img, brate, 4);
    put_le(img, align, 2);
    put_le(img, bits, 2);
    if (fmt_len == FMT_EXT_SIZE) begin
      put_le(img, extra, 2);
      for (int i = 0; i < extra; i++) img.push_back(8'($urandom));
    end
    dtag_at = img.size();
    put_le(img, TAG_DATA, 4);
    put_le(img, dsize, 4);
    pos = 0;
    case (dmg)
      DMG_RIFF: pos = $urandom_range(3);
      DMG_WAVE: pos = 8 + $urandom_range(3);
      DMG_FMT:  pos = 12 + $urandom_range(3);
      DMG_DATA: pos = dtag_at + $urandom_range(3);
      default: ;
    endcase
    if (dmg != DMG_NONE) img[pos] = img[pos] ^ (8'd1 << $urandom_range(7));
    n = (cut == NO_CUT) ? img.size() : cut + 1;
    tail = (cut == NO_CUT) ? trail : 0;
    for (int k = 0; k < n; k++)
      push_byte(img[k], k == 0, with_last && tail == 0 && k == n - 1);
    for (int k = 0; k < tail; k++)
      push_byte(8'($urandom), 1'b0, with_last && k == tail - 1);
    file_items += n + tail;
  endtask

  function automatic logic [15:0] pick16(input int zero_pct);
    int r;
    r = $urandom_range(99);
    if (r < zero_pct) return 16'h0;
    if (r < zero_pct + 8) return 16'hFFFF;
    if (r < 55) return 16'($urandom_range(1, 8));
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] pick32(input int zero_pct);
    int r;
    r = $urandom_range(99);
    if (r < zero_pct) return 32'h0;
    if (r < zero_pct + 8) return 32'hFFFF_FFFF;
    if (r < 55) return 32'($urandom_range(8000, 192000));
    return 32'($urandom);
  endfunction

  task automatic random_file();
    logic [31:0] fmt_len;
    logic [15:0] extra;
    damage_t dmg;
    int hdr_len;
    int cut;
    int r;
    bit with_last;
    r = $urandom_range(99);
    if (r < 60) fmt_len = 32'd16;
    else if (r < 90) fmt_len = FMT_EXT_SIZE;
    else if (r < 95) fmt_len = FMT_EXT_SIZE + 32'($urandom_range(2)) - 32'd1;
    else fmt_len = $urandom;
    extra = ($urandom_range(99) < 15) ? 16'd0 : 16'($urandom_range(1, 6));
    hdr_len = 44 + ((fmt_len == FMT_EXT_SIZE) ? 2 + extra : 0);
    dmg = ($urandom_range(99) < 20) ? damage_t'($urandom_range(1, 4)) : DMG_NONE;
    with_last = $urandom_range(99) < 75;
    cut = NO_CUT;
    r = $urandom_range(99);
    if (dmg != DMG_NONE && r < 30) begin
      // last byte on the byte that breaks the tag
      with_last = 1'b1;
      case (dmg)
        DMG_RIFF: cut = 3;
        DMG_WAVE: cut = 11;
        DMG_FMT:  cut = 15;
        default:  cut = hdr_len - 5;
      endcase
    end else if (r < 45) begin
      cut = $urandom_range(hdr_len - 1);
    end
    make_file(fmt_len, extra, pick16(5), pick32(5), pick32(0), pick16(5), pick16(0),
              pick32(5), dmg, cut, with_last, $urandom_range(4));
    // stray bytes between files, and now and then a short junk file
    r = $urandom_range(99);
    if (r < 25) begin
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0, 1'($urandom_range(1)));
    end else if (r < 30) begin
      push_byte(8'($urandom), 1'b1, 1'b0);
      repeat ($urandom_range(0, 3)) push_byte(8'($urandom), 1'b0, 1'($urandom_range(1)));
      file_items += 2;
    end
  endtask

  // driver: new transaction at the falling edge once the previous one was taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      out_if.ready <= 1'b0;
    end else begin
      if (!in_if.valid || in_fire) begin
        if (byte_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          next_byte = byte_queue.pop_front();
          in_if.data_byte  <= next_byte.data_byte;
          in_if.first_byte <= next_byte.first_byte;
          in_if.last_byte  <= next_byte.last_byte;
          in_if.valid      <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // monitor: predict on each accepted byte, check each accepted result
  always @(posedge clk) begin
    in_fire <= rst_n && in_if.valid && in_if.ready;
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        parse_byte(in_if.data_byte, in_if.first_byte, in_if.last_byte);
      if (out_if.valid && out_if.ready) check_result();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.first_byte = 1'b0;
    in_if.last_byte = 1'b0;
    out_if.ready = 1'b0;

    // directed: idle bytes after reset, one-byte file, bad riff ending on that byte,
    // restart mid-header, all-ones and all-zeros junk
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b1);
    push_byte(8'h52, 1'b1, 1'b1);
    push_byte(8'h52, 1'b1, 1'b0);
    push_byte(8'h49, 1'b0, 1'b0);
    push_byte(8'h46, 1'b0, 1'b0);
    push_byte(8'h58, 1'b0, 1'b1);
    push_byte(8'h52, 1'b1, 1'b0);
    push_byte(8'h49, 1'b0, 1'b0);
    repeat (4) push_byte(8'hFF, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b0);
    repeat (3) push_byte(8'hFF, 1'b0, 1'b1);
    push_byte(8'h00, 1'b1, 1'b0);
    repeat (3) push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hA5, 1'b0, 1'b1);

    while (file_items < RANDOM_ITEMS) random_file();

    // field extremes: all ones, all zeros, odd fmt size, a long extra block last
    make_file(32'd16, 16'd0, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1, 16'hFFFF,
              32'hFFFF_FFFF, DMG_NONE, NO_CUT, 1'b1, 0);
    make_file(32'd16, 16'd0, 16'd0, 32'd0, 32'd0, 16'd0, 16'd0, 32'd0, DMG_NONE, NO_CUT,
              1'b1, 0);
    make_file(32'hFFFF_FFFF, 16'd0, 16'd2, 32'd44100, 32'd176400, 16'd4, 16'd16,
              32'd1000, DMG_NONE, NO_CUT, 1'b0, 2);
    make_file(FMT_EXT_SIZE, 16'd0, 16'd1, 32'd8000, 32'd8000, 16'd1, 16'd8, 32'd7,
              DMG_NONE, NO_CUT, 1'b1, 1);
    make_file(FMT_EXT_SIZE, 16'd64, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
              16'hFFFF, 32'hFFFF_FFFF, DMG_NONE, NO_CUT, 1'b1, 0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (byte_queue.size() != 0 || in_if.valid) @(posedge clk);
    while (header_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
